FILE: design/slpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpt_pkg
// Shared constants and codes for the single-link proximity table.
// ----------------------------------------------------------------------------
package slpt_pkg;

  // default capacity of the cluster list
  localparam int MAX_CLUSTERS_DEF = 64;

  // similarity of an unset pair, -1.0 in Q16.16
  localparam logic signed [31:0] SIM_MINUS_ONE = 32'shFFFF0000;

  // operation codes
  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_SET    = 3'd1,
    OP_MERGE  = 3'd2,
    OP_FIND   = 3'd3,
    OP_REMOVE = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_FEW       = 2'd3
  } stat_t;

endpackage

FILE: design/slpt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpt_ram
// Simple dual-port memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module slpt_ram #(
  parameter int DW = 32,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/single_link_proximity_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_link_proximity_table
// Ordered cluster id list plus lower-triangle similarity table with append,
// pair write, single-link merge, closest-pair search and removal.
// ----------------------------------------------------------------------------
//  channel | ports                                        | direction
//  in      | in_valid/in_ready, op, id_a, id_b, sim_value | beat into block
//  out     | out_valid/out_ready, status, first_id,       | one beat per item
//          | second_id, best_sim                          |
//
// Append, set, merge, search and remove step through the list or table one
// entry at a time; the single read port of the table memory sets their pace.
// Reset clears only control state and the cluster count; each append writes
// its new table row to -1.0, so no clearing pass over the table is needed.
// A new item is taken while the previous result beat still waits on out_ready.
// ----------------------------------------------------------------------------
module single_link_proximity_table import slpt_pkg::*; #(
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_op,
  input  logic [15:0]        in_id_a,
  input  logic [15:0]        in_id_b,
  input  logic signed [31:0] in_sim_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [15:0]        out_first_id,
  output logic [15:0]        out_second_id,
  output logic signed [31:0] out_best_sim
);

  localparam int IW = $clog2(MAX_CLUSTERS);
  localparam int CW = $clog2(MAX_CLUSTERS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_APP, S_FIND, S_SET, S_MERGE, S_SRCH,
    S_SID0, S_SID1, S_SID2, S_RIDS, S_RTAB, S_DONE
  } state_t;

  state_t             state_r;
  op_t                op_r;
  logic [15:0]        ida_r, idb_r;
  logic signed [31:0] sv_r;
  logic [CW-1:0]      count_r, ki_r, row_r, col_r;
  logic               pv_r, fa_r, fb_r, have_r;
  logic [IW-1:0]      pk_r, pj_r, sa_r, sb_r, bi_r, bj_r;
  logic [1:0]         ph_r;
  logic signed [31:0] d_r, best_r;
  logic [15:0]        first_r, second_r;
  stat_t              st_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [15:0]        out_first_r, out_second_r;
  logic signed [31:0] out_best_r;

  // memory ports
  logic               s_we;
  logic [IW-1:0]      s_waddr, s_raddr;
  logic [15:0]        s_wdata, s_rdata;
  logic               t_we;
  logic [2*IW-1:0]    t_waddr, t_raddr;
  logic [31:0]        t_wdata, t_rdata_u;
  logic signed [31:0] t_rdata;

  // loop helpers
  logic [CW-1:0]      ki_inc, row_inc, col_inc;
  logic               k_skip;
  logic [IW-1:0]      src_i, src_j;

  assign t_rdata = signed'(t_rdata_u);
  assign ki_inc  = ki_r + 1'b1;
  assign row_inc = row_r + 1'b1;
  assign col_inc = col_r + 1'b1;
  assign k_skip  = (ki_r[IW-1:0] == sa_r) || (ki_r[IW-1:0] == sb_r);
  assign src_i   = (row_r[IW-1:0] < sa_r) ? row_r[IW-1:0] : row_inc[IW-1:0];
  assign src_j   = (col_r[IW-1:0] < sa_r) ? col_r[IW-1:0] : col_inc[IW-1:0];

  // table address of an unordered slot pair
  function automatic logic [2*IW-1:0] cell_addr(input logic [IW-1:0] a,
                                                input logic [IW-1:0] b);
    cell_addr = (a > b) ? {a, b} : {b, a};
  endfunction

  slpt_ram #(.DW(16), .AW(IW)) u_ids (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  slpt_ram #(.DW(32), .AW(2*IW)) u_sim (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata_u)
  );

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_first_id  = out_first_r;
  assign out_second_id = out_second_r;
  assign out_best_sim  = out_best_r;

  // memory commands from the current step
  always_comb begin
    s_we    = 1'b0;
    s_waddr = pk_r;
    s_wdata = s_rdata;
    s_raddr = ki_r[IW-1:0];
    t_we    = 1'b0;
    t_waddr = {pk_r, pj_r};
    t_wdata = t_rdata_u;
    t_raddr = {row_r[IW-1:0], col_r[IW-1:0]};
    case (state_r)
      S_DISP: begin
        s_we    = (op_r == OP_APPEND) && (count_r != CW'(MAX_CLUSTERS));
        s_waddr = count_r[IW-1:0];
        s_wdata = ida_r;
      end
      S_APP: begin
        t_we    = (ki_r < count_r);
        t_waddr = {count_r[IW-1:0], ki_r[IW-1:0]};
        t_wdata = SIM_MINUS_ONE;
      end
      S_SET: begin
        t_we    = 1'b1;
        t_waddr = cell_addr(sa_r, sb_r);
        t_wdata = sv_r;
      end
      S_MERGE: begin
        t_raddr = (ph_r == 2'd0) ? cell_addr(sa_r, ki_r[IW-1:0])
                                 : cell_addr(sb_r, ki_r[IW-1:0]);
        t_we    = (ph_r == 2'd2) && (t_rdata > d_r);
        t_waddr = cell_addr(sa_r, ki_r[IW-1:0]);
      end
      S_SID0: s_raddr = bj_r;
      S_SID1: s_raddr = bi_r;
      S_RIDS: begin
        s_raddr = ki_inc[IW-1:0];
        s_we    = pv_r;
      end
      S_RTAB: begin
        t_raddr = {src_i, src_j};
        t_we    = pv_r;
      end
      default: ;
    endcase
  end

  // sequencer, loop counters and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= op_t'(in_op);
            ida_r   <= in_id_a;
            idb_r   <= in_id_b;
            sv_r    <= in_sim_value;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          st_r     <= ST_OK;
          first_r  <= '0;
          second_r <= '0;
          best_r   <= '0;
          ki_r     <= '0;
          pv_r     <= 1'b0;
          fa_r     <= 1'b0;
          fb_r     <= 1'b0;
          have_r   <= 1'b0;
          row_r    <= CW'(1);
          col_r    <= '0;
          ph_r     <= 2'd0;
          case (op_r)
            OP_APPEND: begin
              if (count_r == CW'(MAX_CLUSTERS)) begin
                st_r    <= ST_FULL;
                state_r <= S_DONE;
              end else begin
                state_r <= S_APP;
              end
            end
            OP_SET, OP_MERGE, OP_REMOVE: state_r <= S_FIND;
            OP_FIND: begin
              if (count_r < CW'(2)) begin
                st_r    <= ST_FEW;
                state_r <= S_DONE;
              end else begin
                state_r <= S_SRCH;
              end
            end
            default: state_r <= S_DONE;
          endcase
        end
        // new row starts at -1.0
        S_APP: begin
          if (ki_r < count_r) begin
            ki_r <= ki_inc;
          end else begin
            count_r <= count_r + 1'b1;
            state_r <= S_DONE;
          end
        end
        // id lookup, earliest slot wins
        S_FIND: begin
          if (ki_r < count_r) begin
            ki_r <= ki_inc;
            pv_r <= 1'b1;
            pk_r <= ki_r[IW-1:0];
          end else begin
            pv_r <= 1'b0;
          end
          if (pv_r) begin
            if (!fa_r && s_rdata == ida_r) begin
              fa_r <= 1'b1;
              sa_r <= pk_r;
            end
            if (!fb_r && s_rdata == idb_r) begin
              fb_r <= 1'b1;
              sb_r <= pk_r;
            end
          end
          if (ki_r >= count_r && !pv_r) begin
            ki_r <= (op_r == OP_REMOVE) ? CW'(sa_r) : '0;
            if (op_r == OP_REMOVE) begin
              if (!fa_r) begin
                st_r    <= ST_NOT_FOUND;
                state_r <= S_DONE;
              end else begin
                first_r <= ida_r;
                state_r <= S_RIDS;
              end
            end else if (!fa_r || !fb_r) begin
              st_r    <= ST_NOT_FOUND;
              state_r <= S_DONE;
            end else if (sa_r == sb_r) begin
              state_r <= S_DONE;
            end else if (op_r == OP_SET) begin
              state_r <= S_SET;
            end else begin
              state_r <= S_MERGE;
            end
          end
        end
        S_SET: state_r <= S_DONE;
        // read dest, read source, write back the larger
        S_MERGE: begin
          if (ki_r >= count_r) begin
            state_r <= S_DONE;
          end else if (k_skip) begin
            ki_r <= ki_inc;
          end else begin
            case (ph_r)
              2'd0: ph_r <= 2'd1;
              2'd1: begin
                d_r  <= t_rdata;
                ph_r <= 2'd2;
              end
              default: begin
                ph_r <= 2'd0;
                ki_r <= ki_inc;
              end
            endcase
          end
        end
        // row-major scan, first strict maximum kept
        S_SRCH: begin
          if (row_r < count_r) begin
            pv_r <= 1'b1;
            pk_r <= row_r[IW-1:0];
            pj_r <= col_r[IW-1:0];
            if (col_inc == row_r) begin
              row_r <= row_inc;
              col_r <= '0;
            end else begin
              col_r <= col_inc;
            end
          end else begin
            pv_r <= 1'b0;
          end
          if (pv_r && (!have_r || t_rdata > best_r)) begin
            have_r <= 1'b1;
            best_r <= t_rdata;
            bi_r   <= pk_r;
            bj_r   <= pj_r;
          end
          if (row_r >= count_r && !pv_r) begin
            state_r <= S_SID0;
          end
        end
        S_SID0: state_r <= S_SID1;
        S_SID1: begin
          first_r <= s_rdata;
          state_r <= S_SID2;
        end
        S_SID2: begin
          second_r <= s_rdata;
          state_r  <= S_DONE;
        end
        // close the gap in the id list
        S_RIDS: begin
          if (ki_inc < count_r) begin
            ki_r <= ki_inc;
            pv_r <= 1'b1;
            pk_r <= ki_r[IW-1:0];
          end else begin
            pv_r <= 1'b0;
          end
          if (!(ki_inc < count_r) && !pv_r) begin
            row_r   <= CW'(1);
            col_r   <= '0;
            state_r <= S_RTAB;
          end
        end
        // close the gap in the table, copy one entry per cycle
        S_RTAB: begin
          if (row_inc < count_r) begin
            pv_r <= 1'b1;
            pk_r <= row_r[IW-1:0];
            pj_r <= col_r[IW-1:0];
            if (col_inc == row_r) begin
              row_r <= row_inc;
              col_r <= '0;
            end else begin
              col_r <= col_inc;
            end
          end else begin
            pv_r <= 1'b0;
            if (!pv_r) begin
              count_r <= count_r - 1'b1;
              state_r <= S_DONE;
            end
          end
        end
        // hand the result beat to the output register
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= st_r;
            out_first_r  <= first_r;
            out_second_r <= second_r;
            out_best_r   <= best_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
